// ===== design/qcbi_pkg.sv =====
package qcbi_pkg;

    // Unit coordinates carry 16 fraction bits and saturate to [-4, 4).
    localparam int UNIT_FRAC = 16;
    localparam int UNIT_W    = UNIT_FRAC + 3;

    // Interpolation mode codes.
    localparam logic MODE_BICUBIC  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    // Per-item control that rides alongside the datapath.
    typedef struct packed {
        logic mode;
        logic invalid;
    } t_side;

endpackage

// ===== design/qcbi_delay.sv =====
module qcbi_delay #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [N];

    // Shift line that keeps side data aligned with a pipelined unit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[N-1];

endmodule

// ===== design/qcbi_front.sv =====
module qcbi_front #(
    parameter int VW = 16,
    parameter int CW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic                    i_mode,
    input  logic signed [VW-1:0]    i_tl,
    input  logic signed [VW-1:0]    i_tr,
    input  logic signed [VW-1:0]    i_br,
    input  logic signed [VW-1:0]    i_bl,
    input  logic [CW-1:0]           i_left,
    input  logic [CW-1:0]           i_top,
    input  logic [CW-1:0]           i_right,
    input  logic [CW-1:0]           i_bottom,
    input  logic [CW-1:0]           i_x,
    input  logic [CW-1:0]           i_y,
    output logic                    o_valid,
    output qcbi_pkg::t_side         o_side,
    output logic signed [VW-1:0]    o_tl,
    output logic signed [VW-1:0]    o_tr,
    output logic signed [VW-1:0]    o_br,
    output logic signed [VW-1:0]    o_bl,
    output logic [2*CW+VW+1:0]      o_unx,
    output logic [2*CW-1:0]         o_udx,
    output logic                    o_negx,
    output logic [CW+qcbi_pkg::UNIT_FRAC:0] o_uny,
    output logic [CW-1:0]           o_udy,
    output logic                    o_negy
);
    import qcbi_pkg::*;

    localparam int DW   = CW + 1;
    localparam int PW   = CW + 1 + VW;
    localparam int HW   = 2 * CW + 2;
    localparam int SUMW = CW + VW + 2;
    localparam int TBW  = 2 * CW + VW + 3;
    localparam int NW   = 2 * CW + VW + 4;
    localparam int DWX  = 2 * CW + VW + 2;
    localparam int LYW  = CW + 1 + UNIT_FRAC;

    logic [5:0] r_v;
    t_side      r_side [6];
    logic signed [VW-1:0] r_tl [6];
    logic signed [VW-1:0] r_tr [6];
    logic signed [VW-1:0] r_br [6];
    logic signed [VW-1:0] r_bl [6];

    logic signed [DW-1:0] r_w1, r_h1, r_dx1, r_dy1, r_rx1, r_by1;
    logic signed [DW-1:0] r_w2, r_h2, r_dx2, r_dy2, r_by2;
    logic signed [DW-1:0] r_w3, r_h3, r_dx3, r_dy3, r_by3;
    logic signed [DW-1:0] r_w4, r_h4, r_dx4, r_dy4;
    logic signed [PW-1:0] r_ptl, r_ptr, r_pbl, r_pbr;
    logic signed [HW-1:0] r_den2, r_den3, r_den4, r_dnx;
    logic signed [SUMW-1:0] r_top, r_bot;
    logic signed [TBW-1:0] r_pt, r_pb;
    logic signed [NW-1:0] r_nx;
    logic signed [LYW-1:0] r_ny;
    logic signed [DW-1:0] r_dny;

    logic signed [DW-1:0]  n_w, n_h, n_dx, n_dy, n_rx, n_by;
    logic signed [NW-1:0]  n_nx, w_anx;
    logic signed [HW-1:0]  n_dnx, w_adx;
    logic signed [LYW-1:0] w_dxs, w_dys, w_any;
    logic signed [DW-1:0]  w_ahy;
    t_side                 n_side;

    // Edge differences of the first stage.
    always_comb begin
        n_w  = $signed({1'b0, i_right}) - $signed({1'b0, i_left});
        n_h  = $signed({1'b0, i_bottom}) - $signed({1'b0, i_top});
        n_dx = $signed({1'b0, i_x}) - $signed({1'b0, i_left});
        n_dy = $signed({1'b0, i_y}) - $signed({1'b0, i_top});
        n_rx = $signed({1'b0, i_right}) - $signed({1'b0, i_x});
        n_by = $signed({1'b0, i_bottom}) - $signed({1'b0, i_y});
        n_side.mode    = i_mode;
        n_side.invalid = (i_right == i_left) || (i_bottom == i_top);
    end

    // Lane selection: bicubic divides offsets by the spans, bilinear divides
    // the blended sum by the area.
    always_comb begin
        w_dxs = $signed({r_dx4, {UNIT_FRAC{1'b0}}});
        w_dys = $signed({r_dy4, {UNIT_FRAC{1'b0}}});
        if (r_side[3].mode == MODE_BICUBIC) begin
            n_nx  = NW'(w_dxs);
            n_dnx = HW'(r_w4);
        end else begin
            n_nx  = NW'(r_pt) + NW'(r_pb);
            n_dnx = r_den4;
        end
    end

    // Magnitudes for the unsigned dividers.
    always_comb begin
        w_anx = r_nx[NW-1] ? -r_nx : r_nx;
        w_adx = r_dnx[HW-1] ? -r_dnx : r_dnx;
        w_any = r_ny[LYW-1] ? -r_ny : r_ny;
        w_ahy = r_dny[DW-1] ? -r_dny : r_dny;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // Corners and control shift along all six stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= n_side;
            r_tl[0]   <= i_tl;
            r_tr[0]   <= i_tr;
            r_br[0]   <= i_br;
            r_bl[0]   <= i_bl;
            for (int k = 1; k < 6; k++) begin
                r_side[k] <= r_side[k-1];
                r_tl[k]   <= r_tl[k-1];
                r_tr[k]   <= r_tr[k-1];
                r_br[k]   <= r_br[k-1];
                r_bl[k]   <= r_bl[k-1];
            end
        end
    end

    // Datapath stages one to six.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1  <= n_w;
            r_h1  <= n_h;
            r_dx1 <= n_dx;
            r_dy1 <= n_dy;
            r_rx1 <= n_rx;
            r_by1 <= n_by;

            r_ptl  <= r_rx1 * r_tl[0];
            r_ptr  <= r_dx1 * r_tr[0];
            r_pbl  <= r_rx1 * r_bl[0];
            r_pbr  <= r_dx1 * r_br[0];
            r_den2 <= r_w1 * r_h1;
            r_w2   <= r_w1;
            r_h2   <= r_h1;
            r_dx2  <= r_dx1;
            r_dy2  <= r_dy1;
            r_by2  <= r_by1;

            r_top  <= SUMW'(r_ptl) + SUMW'(r_ptr);
            r_bot  <= SUMW'(r_pbl) + SUMW'(r_pbr);
            r_den3 <= r_den2;
            r_w3   <= r_w2;
            r_h3   <= r_h2;
            r_dx3  <= r_dx2;
            r_dy3  <= r_dy2;
            r_by3  <= r_by2;

            r_pt   <= r_by3 * r_top;
            r_pb   <= r_dy3 * r_bot;
            r_den4 <= r_den3;
            r_w4   <= r_w3;
            r_h4   <= r_h3;
            r_dx4  <= r_dx3;
            r_dy4  <= r_dy3;

            r_nx  <= n_nx;
            r_dnx <= n_dnx;
            r_ny  <= w_dys;
            r_dny <= r_h4;

            o_unx  <= w_anx[DWX-1:0] + DWX'(w_adx[2*CW-1:1]);
            o_udx  <= w_adx[2*CW-1:0];
            o_negx <= r_nx[NW-1] ^ r_dnx[HW-1];
            o_uny  <= w_any + LYW'(w_ahy[CW-1:1]);
            o_udy  <= w_ahy[CW-1:0];
            o_negy <= r_ny[LYW-1] ^ r_dny[DW-1];
        end
    end

    assign o_valid = r_v[5];
    assign o_side  = r_side[5];
    assign o_tl    = r_tl[5];
    assign o_tr    = r_tr[5];
    assign o_br    = r_br[5];
    assign o_bl    = r_bl[5];

endmodule

// ===== design/qcbi_div.sv =====
module qcbi_div #(
    parameter int DW = 32,
    parameter int SW = 16,
    parameter int QB = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [SW-1:0] i_den,
    input  logic          i_neg,
    output logic          o_valid,
    output logic [QB-1:0] o_quo,
    output logic          o_ovf,
    output logic          o_neg
);

    localparam int DWP = (DW > QB) ? DW : QB + 1;
    localparam int HW  = DWP - QB;
    localparam int CWD = (HW > SW) ? HW : SW;

    logic [QB:0]    r_v;
    logic [SW-1:0]  r_rem [QB+1];
    logic [QB-1:0]  r_lq  [QB+1];
    logic [SW-1:0]  r_den [QB];
    logic           r_ovf [QB+1];
    logic           r_neg [QB+1];

    logic [DWP-1:0] w_pad;
    logic [HW-1:0]  w_hi;

    // The quotient is limited to QB bits; a larger one is flagged.
    assign w_pad = DWP'(i_num);
    assign w_hi  = w_pad[DWP-1:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= SW'(w_hi);
            r_lq[0]  <= w_pad[QB-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= CWD'(w_hi) >= CWD'(i_den);
            r_neg[0] <= i_neg;
        end
    end

    // One restoring step per stage: dividend bits shift out of the top of
    // the lq word while quotient bits shift in at the bottom.
    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [SW:0] w_trial;
        logic        w_ge;

        assign w_trial = {r_rem[k-1], r_lq[k-1][QB-1]};
        assign w_ge    = w_trial >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? SW'(w_trial - {1'b0, r_den[k-1]}) : w_trial[SW-1:0];
                r_lq[k]  <= {r_lq[k-1][QB-2:0], w_ge};
                r_ovf[k] <= r_ovf[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end

        if (k < QB) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_quo   = r_lq[QB];
    assign o_ovf   = r_ovf[QB] || (r_rem[QB] != r_rem[QB]);
    assign o_neg   = r_neg[QB];

endmodule

// ===== design/qcbi_cubic.sv =====
module qcbi_cubic #(
    parameter int VW = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [VW-1:0]              i_p0,
    input  logic signed [VW-1:0]              i_p1,
    input  logic signed [VW-1:0]              i_p2,
    input  logic signed [VW-1:0]              i_p3,
    input  logic signed [qcbi_pkg::UNIT_W-1:0] i_t,
    output logic                              o_valid,
    output logic signed [VW-1:0]              o_r
);
    import qcbi_pkg::*;

    localparam int TW  = UNIT_W;
    localparam int AW  = VW + 1;
    localparam int BW  = VW + 4;
    localparam int TCW = TW + BW;
    localparam int IW  = TCW + 1;
    localparam int TIW = TW + IW;
    localparam int RW  = TIW - UNIT_FRAC;
    localparam int MW  = RW + 1;
    localparam int TMW = TW + MW;
    localparam int SH2 = 2 * UNIT_FRAC + 1;
    localparam int R2W = TMW - SH2;
    localparam int S3W = R2W + 1;

    localparam logic signed [TIW-1:0] HALF1 = TIW'(1) <<< (UNIT_FRAC - 1);
    localparam logic signed [TMW-1:0] HALF2 = TMW'(1) <<< (SH2 - 1);
    localparam logic signed [S3W-1:0] VMAX  = (S3W'(1) <<< (VW - 1)) - S3W'(1);
    localparam logic signed [S3W-1:0] VMIN  = -(S3W'(1) <<< (VW - 1));

    logic [8:0] r_v;
    logic signed [TW-1:0] r_t  [6];
    logic signed [VW-1:0] r_p1 [8];
    logic signed [AW-1:0] r_a  [5];
    logic signed [BW-1:0] r_b, r_b2, r_c;
    logic signed [TCW-1:0] r_tc;
    logic signed [IW-1:0]  r_i;
    logic signed [TIW-1:0] r_ti;
    logic signed [RW-1:0]  r_rr;
    logic signed [MW-1:0]  r_m;
    logic signed [TMW-1:0] r_tm;
    logic signed [R2W-1:0] r_rr2;

    logic signed [BW-1:0]  w_p0, w_p1, w_p2, w_p3, w_d;
    logic signed [TIW-1:0] w_s1;
    logic signed [TMW-1:0] w_s2;
    logic signed [S3W-1:0] w_sum;

    // Spline coefficients from the four control values.
    always_comb begin
        w_p0 = BW'(i_p0);
        w_p1 = BW'(i_p1);
        w_p2 = BW'(i_p2);
        w_p3 = BW'(i_p3);
        w_d  = w_p1 - w_p2;
    end

    // Round-half-away shifts: add half, less one for negative values.
    assign w_s1  = r_ti + HALF1 - TIW'($signed({1'b0, r_ti[TIW-1]}));
    assign w_s2  = r_tm + HALF2 - TMW'($signed({1'b0, r_tm[TMW-1]}));
    assign w_sum = S3W'(r_rr2) + S3W'(r_p1[7]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:0], i_valid};
        end
    end

    // Operands that skip stages ride in short shift lines.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0]  <= i_t;
            r_p1[0] <= i_p1;
            r_a[0]  <= AW'(i_p2) - AW'(i_p0);
            for (int k = 1; k < 6; k++) begin
                r_t[k] <= r_t[k-1];
            end
            for (int k = 1; k < 8; k++) begin
                r_p1[k] <= r_p1[k-1];
            end
            for (int k = 1; k < 5; k++) begin
                r_a[k] <= r_a[k-1];
            end
        end
    end

    // Horner evaluation, one multiply or one wide add per stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b   <= (w_p0 <<< 1) - (w_p1 <<< 2) - w_p1 + (w_p2 <<< 2) - w_p3;
            r_c   <= (w_d <<< 1) + w_d + w_p3 - w_p0;
            r_tc  <= r_t[0] * r_c;
            r_b2  <= r_b;
            r_i   <= IW'(r_tc) + IW'($signed({r_b2, {UNIT_FRAC{1'b0}}}));
            r_ti  <= r_t[2] * r_i;
            r_rr  <= RW'(w_s1 >>> UNIT_FRAC);
            r_m   <= MW'(r_rr) + MW'($signed({r_a[4], {UNIT_FRAC{1'b0}}}));
            r_tm  <= r_t[5] * r_m;
            r_rr2 <= R2W'(w_s2 >>> SH2);
            if (w_sum > VMAX) begin
                o_r <= VMAX[VW-1:0];
            end else if (w_sum < VMIN) begin
                o_r <= VMIN[VW-1:0];
            end else begin
                o_r <= w_sum[VW-1:0];
            end
        end
    end

    assign o_valid = r_v[8];

endmodule

// ===== design/quad_corner_bicubic_interpolator.sv =====
// Interpolates one value per transfer from the four corners of a rectangle.
// The block accepts one item every clock while no valid result is held by
// i_stall, and returns results in order. Two restoring dividers, one
// quotient bit per stage with QB = max(VALUE_WIDTH + 1, 19), sit between a
// six-stage front end and three nine-stage cubic pass units (two y passes,
// then the x pass). When the output is held by i_stall the whole pipeline
// holds, so o_stall rises in the same cycle and no item is lost or
// repeated.
module quad_corner_bicubic_interpolator #(
    parameter int VALUE_WIDTH = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic signed [VALUE_WIDTH-1:0] i_tl_value,
    input  logic signed [VALUE_WIDTH-1:0] i_tr_value,
    input  logic signed [VALUE_WIDTH-1:0] i_br_value,
    input  logic signed [VALUE_WIDTH-1:0] i_bl_value,
    input  logic [COORD_WIDTH-1:0]        i_left_edge,
    input  logic [COORD_WIDTH-1:0]        i_top_edge,
    input  logic [COORD_WIDTH-1:0]        i_right_edge,
    input  logic [COORD_WIDTH-1:0]        i_bottom_edge,
    input  logic [COORD_WIDTH-1:0]        i_sample_x,
    input  logic [COORD_WIDTH-1:0]        i_sample_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_result_value,
    output logic                          o_invalid
);
    import qcbi_pkg::*;

    localparam int VW  = VALUE_WIDTH;
    localparam int CW  = COORD_WIDTH;
    localparam int TW  = UNIT_W;
    localparam int DWX = 2 * CW + VW + 2;
    localparam int SWX = 2 * CW;
    localparam int DWY = CW + UNIT_FRAC + 1;
    localparam int QB  = (VW + 1 > TW) ? VW + 1 : TW;
    localparam int SDW = $bits(t_side);
    localparam int CNW = 4 * VW;

    localparam logic [QB-1:0] QU_MAX = (QB'(1) << (TW - 1)) - QB'(1);
    localparam logic [QB-1:0] QV_MAX = (QB'(1) << (VW - 1)) - QB'(1);
    localparam logic signed [TW-1:0] U_MAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] U_MIN = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

    logic w_adv;

    logic               w_fv, w_negx, w_negy;
    t_side              w_fside;
    logic signed [VW-1:0] w_ftl, w_ftr, w_fbr, w_fbl;
    logic [DWX-1:0]     w_unx;
    logic [SWX-1:0]     w_udx;
    logic [DWY-1:0]     w_uny;
    logic [CW-1:0]      w_udy;

    logic               w_vx, w_vy, w_ovx, w_ovy, w_dnx, w_dny;
    logic [QB-1:0]      w_qx, w_qy;
    logic [SDW+CNW-1:0] w_dside;
    t_side              w_dsd;
    logic signed [VW-1:0] w_dtl, w_dtr, w_dbr, w_dbl;

    logic signed [TW-1:0] n_ux, n_uy;
    logic signed [VW-1:0] n_bil;

    logic               r_pv;
    t_side              r_pside;
    logic signed [TW-1:0] r_ux, r_uy;
    logic signed [VW-1:0] r_bil, r_tl, r_tr, r_br, r_bl;

    logic               w_vl, w_vr, w_vc;
    logic signed [VW-1:0] w_cl, w_cr, w_cx;
    logic signed [TW-1:0] w_uxd;
    logic [SDW+VW-1:0]  w_sb1, w_sb2;
    t_side              w_fs;
    logic signed [VW-1:0] w_fbil;

    logic               r_out_valid;
    logic signed [VW-1:0] r_res;
    logic               r_inv;

    // The pipeline moves unless a finished result is being held.
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    qcbi_front #(.VW(VW), .CW(CW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_tl     (i_tl_value),
        .i_tr     (i_tr_value),
        .i_br     (i_br_value),
        .i_bl     (i_bl_value),
        .i_left   (i_left_edge),
        .i_top    (i_top_edge),
        .i_right  (i_right_edge),
        .i_bottom (i_bottom_edge),
        .i_x      (i_sample_x),
        .i_y      (i_sample_y),
        .o_valid  (w_fv),
        .o_side   (w_fside),
        .o_tl     (w_ftl),
        .o_tr     (w_ftr),
        .o_br     (w_fbr),
        .o_bl     (w_fbl),
        .o_unx    (w_unx),
        .o_udx    (w_udx),
        .o_negx   (w_negx),
        .o_uny    (w_uny),
        .o_udy    (w_udy),
        .o_negy   (w_negy)
    );

    // Lane X: x unit coordinate, or the bilinear quotient.
    qcbi_div #(.DW(DWX), .SW(SWX), .QB(QB)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_fv),
        .i_num   (w_unx),
        .i_den   (w_udx),
        .i_neg   (w_negx),
        .o_valid (w_vx),
        .o_quo   (w_qx),
        .o_ovf   (w_ovx),
        .o_neg   (w_dnx)
    );

    // Lane Y: y unit coordinate.
    qcbi_div #(.DW(DWY), .SW(CW), .QB(QB)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_fv),
        .i_num   (w_uny),
        .i_den   (w_udy),
        .i_neg   (w_negy),
        .o_valid (w_vy),
        .o_quo   (w_qy),
        .o_ovf   (w_ovy),
        .o_neg   (w_dny)
    );

    qcbi_delay #(.W(SDW + CNW), .N(QB + 1)) u_dly_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({w_fside, w_ftl, w_ftr, w_fbr, w_fbl}),
        .o_q   (w_dside)
    );

    assign {w_dsd, w_dtl, w_dtr, w_dbr, w_dbl} = w_dside;

    // Apply signs and saturate the quotients.
    always_comb begin
        if (!w_dnx) begin
            n_ux  = (w_ovx || w_qx > QU_MAX) ? U_MAX : w_qx[TW-1:0];
            n_bil = (w_ovx || w_qx > QV_MAX) ? V_MAX : w_qx[VW-1:0];
        end else begin
            n_ux  = (w_ovx || w_qx > QU_MAX + QB'(1)) ? U_MIN : -w_qx[TW-1:0];
            n_bil = (w_ovx || w_qx > QV_MAX + QB'(1)) ? V_MIN : -w_qx[VW-1:0];
        end
        if (!w_dny) begin
            n_uy = (w_ovy || w_qy > QU_MAX) ? U_MAX : w_qy[TW-1:0];
        end else begin
            n_uy = (w_ovy || w_qy > QU_MAX + QB'(1)) ? U_MIN : -w_qy[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_adv) begin
            r_pv <= w_vx && w_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pside <= w_dsd;
            r_ux    <= n_ux;
            r_uy    <= n_uy;
            r_bil   <= n_bil;
            r_tl    <= w_dtl;
            r_tr    <= w_dtr;
            r_br    <= w_dbr;
            r_bl    <= w_dbl;
        end
    end

    // Y passes over the replicated left and right columns.
    qcbi_cubic #(.VW(VW)) u_cubic_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_pv),
        .i_p0    (r_tl),
        .i_p1    (r_tl),
        .i_p2    (r_bl),
        .i_p3    (r_bl),
        .i_t     (r_uy),
        .o_valid (w_vl),
        .o_r     (w_cl)
    );

    qcbi_cubic #(.VW(VW)) u_cubic_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_pv),
        .i_p0    (r_tr),
        .i_p1    (r_tr),
        .i_p2    (r_br),
        .i_p3    (r_br),
        .i_t     (r_uy),
        .o_valid (w_vr),
        .o_r     (w_cr)
    );

    qcbi_delay #(.W(TW), .N(9)) u_dly_ux (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (r_ux),
        .o_q   (w_uxd)
    );

    qcbi_delay #(.W(SDW + VW), .N(9)) u_dly_sb1 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({r_pside, r_bil}),
        .o_q   (w_sb1)
    );

    // X pass over the column results.
    qcbi_cubic #(.VW(VW)) u_cubic_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_vl && w_vr),
        .i_p0    (w_cl),
        .i_p1    (w_cl),
        .i_p2    (w_cr),
        .i_p3    (w_cr),
        .i_t     (w_uxd),
        .o_valid (w_vc),
        .o_r     (w_cx)
    );

    qcbi_delay #(.W(SDW + VW), .N(9)) u_dly_sb2 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (w_sb1),
        .o_q   (w_sb2)
    );

    assign {w_fs, w_fbil} = w_sb2;

    // Output register: pick the mode's result, or zero for a flat quad.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_inv <= w_fs.invalid;
            if (w_fs.invalid) begin
                r_res <= '0;
            end else if (w_fs.mode == MODE_BILINEAR) begin
                r_res <= w_fbil;
            end else begin
                r_res <= w_cx;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_res;
    assign o_invalid      = r_inv;

endmodule

// ===== design/qcbi_checker.sv =====
module qcbi_checker #(
    parameter int VW = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input logic [VW-1:0] o_result_value,
    input logic          o_invalid
);

    // A held result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value) && $stable(o_invalid))
        else $error("held result changed");

    // A flat quad reports zero.
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_result_value == '0)
        else $error("invalid result is not zero");

    // A held result stalls the input side in the same cycle.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input not stalled while output held");

    // Without a held result the input side is free.
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind quad_corner_bicubic_interpolator qcbi_checker #(.VW(VALUE_WIDTH)) u_qcbi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_value (o_result_value),
    .o_invalid      (o_invalid)
);

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qcbi_pkg::*;

    localparam int VW = 16;
    localparam int CW = 16;
    localparam int DRAIN_CYCLES = 100;
    localparam longint VAL_MAX = 32767;
    localparam longint VAL_MIN = -32768;
    localparam longint UNIT_ONE = 64'sd1 <<< UNIT_FRAC;
    localparam longint UNIT_HI = (64'sd4 <<< UNIT_FRAC) - 1;
    localparam longint UNIT_LO = -(64'sd4 <<< UNIT_FRAC);

    typedef struct {
        logic                 mode;
        logic signed [VW-1:0] tl, tr, br, bl;
        logic [CW-1:0]        le, te, re, be, sx, sy;
    } t_sample;

    typedef struct {
        logic signed [VW-1:0] value;
        logic                 invalid;
    } t_point;

    // One directed row; fixed marks a row whose answer is typed in.
    typedef struct {
        t_sample smp;
        bit      fixed;
        t_point  answer;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_mode = MODE_BICUBIC;
    logic signed [VW-1:0] i_tl_value = '0;
    logic signed [VW-1:0] i_tr_value = '0;
    logic signed [VW-1:0] i_br_value = '0;
    logic signed [VW-1:0] i_bl_value = '0;
    logic [CW-1:0]        i_left_edge = '0;
    logic [CW-1:0]        i_top_edge = '0;
    logic [CW-1:0]        i_right_edge = '0;
    logic [CW-1:0]        i_bottom_edge = '0;
    logic [CW-1:0]        i_sample_x = '0;
    logic [CW-1:0]        i_sample_y = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [VW-1:0] o_result_value;
    logic                 o_invalid;

    t_point pending_points[$];
    int     error_count = 0;
    bit     stimulus_done = 1'b0;

    quad_corner_bicubic_interpolator #(
        .VALUE_WIDTH(VW),
        .COORD_WIDTH(CW)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_mode(i_mode),
        .i_tl_value(i_tl_value),
        .i_tr_value(i_tr_value),
        .i_br_value(i_br_value),
        .i_bl_value(i_bl_value),
        .i_left_edge(i_left_edge),
        .i_top_edge(i_top_edge),
        .i_right_edge(i_right_edge),
        .i_bottom_edge(i_bottom_edge),
        .i_sample_x(i_sample_x),
        .i_sample_y(i_sample_y),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_result_value(o_result_value),
        .o_invalid(o_invalid)
    );

    always #1 i_clk = ~i_clk;

    // Divide and round to nearest, ties away from zero.
    function automatic longint div_nearest(longint num, longint den);
        longint un, ud, q;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (un + ud / 2) / ud;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic longint clamp_value(longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    function automatic longint to_unit(longint offset, longint span);
        longint t;
        t = div_nearest(offset * UNIT_ONE, span);
        if (t > UNIT_HI) return UNIT_HI;
        if (t < UNIT_LO) return UNIT_LO;
        return t;
    endfunction

    // One Catmull-Rom segment between p1 and p2 at unit position t.
    function automatic longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
                                           longint t);
        longint a, b, c, lin, quad;
        a = p2 - p0;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = 3 * (p1 - p2) + p3 - p0;
        lin = b * UNIT_ONE + t * c;
        quad = a * UNIT_ONE + div_nearest(t * lin, UNIT_ONE);
        return clamp_value(p1 + div_nearest(t * quad, 2 * UNIT_ONE * UNIT_ONE));
    endfunction

    function automatic t_point interpolate(t_sample s);
        t_point p;
        longint tl, tr, br, bl, le, te, re, be, x, y, w, h, ux, uy, c0, c2, top, bot, res;
        tl = s.tl; tr = s.tr; br = s.br; bl = s.bl;
        le = s.le; te = s.te; re = s.re; be = s.be; x = s.sx; y = s.sy;
        w = re - le;
        h = be - te;
        if (w == 0 || h == 0) begin
            p.value = '0;
            p.invalid = 1'b1;
            return p;
        end
        if (s.mode == MODE_BICUBIC) begin
            ux = to_unit(x - le, w);
            uy = to_unit(y - te, h);
            c0 = catmull_rom(tl, tl, bl, bl, uy);
            c2 = catmull_rom(tr, tr, br, br, uy);
            res = catmull_rom(c0, c0, c2, c2, ux);
        end else begin
            top = (re - x) * tl + (x - le) * tr;
            bot = (re - x) * bl + (x - le) * br;
            res = clamp_value(div_nearest((be - y) * top + (y - te) * bot, w * h));
        end
        p.value = res[VW-1:0];
        p.invalid = 1'b0;
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Drive one item and hold it until the block takes the transfer.
    task automatic send_sample(t_sample s, t_point want);
        i_valid <= 1'b1;
        i_mode <= s.mode;
        i_tl_value <= s.tl;
        i_tr_value <= s.tr;
        i_br_value <= s.br;
        i_bl_value <= s.bl;
        i_left_edge <= s.le;
        i_top_edge <= s.te;
        i_right_edge <= s.re;
        i_bottom_edge <= s.be;
        i_sample_x <= s.sx;
        i_sample_y <= s.sy;
        do @(posedge i_clk); while (o_stall);
        pending_points.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        s.mode = 1'($urandom_range(0, 1));
        s.tl = VW'($urandom); s.tr = VW'($urandom);
        s.br = VW'($urandom); s.bl = VW'($urandom);
        if ($urandom_range(0, 9) < 8) begin
            // Well-formed rectangle, now and then made flat, sample mostly inside, sometimes nearby.
            s.le = CW'($urandom_range(0, 60000));
            s.re = CW'(s.le + $urandom_range(1, 5000));
            s.te = CW'($urandom_range(0, 60000));
            s.be = CW'(s.te + $urandom_range(1, 5000));
            if ($urandom_range(0, 3) != 0) begin
                s.sx = CW'($urandom_range(s.le, s.re));
                s.sy = CW'($urandom_range(s.te, s.be));
            end else begin
                s.sx = CW'(s.le + $urandom_range(0, 3 * (s.re - s.le)) - (s.re - s.le));
                s.sy = CW'(s.te + $urandom_range(0, 3 * (s.be - s.te)) - (s.be - s.te));
            end
            if ($urandom_range(0, 19) == 0) s.re = s.le;
            if ($urandom_range(0, 19) == 0) s.be = s.te;
        end else begin
            s.le = CW'($urandom); s.te = CW'($urandom);
            s.re = CW'($urandom); s.be = CW'($urandom);
            s.sx = CW'($urandom); s.sy = CW'($urandom);
        end
        return s;
    endfunction

    function automatic t_row mk_row(logic mode, int tl, int tr, int br, int bl,
                                    int le, int te, int re, int be, int sx, int sy,
                                    bit fixed, int value, logic inv);
        t_row r;
        r.smp = '{mode, VW'(tl), VW'(tr), VW'(br), VW'(bl),
                  CW'(le), CW'(te), CW'(re), CW'(be), CW'(sx), CW'(sy)};
        r.fixed = fixed;
        r.answer.value = VW'(value);
        r.answer.invalid = inv;
        return r;
    endfunction

    // Stimulus: directed table, a full drain, then bursts of random items.
    initial begin
        t_row   rows[$];
        int     burst, gap;
        bit     steady;
        rows.push_back(mk_row(MODE_BICUBIC, 100, 200, 300, 400, 10, 10, 10, 50, 20, 20,
                              1, 0, 1));
        rows.push_back(mk_row(MODE_BILINEAR, 100, 200, 300, 400, 10, 10, 90, 10, 20, 20,
                              1, 0, 1));
        rows.push_back(mk_row(MODE_BICUBIC, 32767, -32768, 0, 5, 0, 0, 65535, 65535, 0, 0,
                              1, 32767, 0));
        rows.push_back(mk_row(MODE_BILINEAR, -32768, 32767, 1, 2, 16, 32, 160, 320, 16, 32,
                              1, -32768, 0));
        rows.push_back(mk_row(MODE_BILINEAR, 7, 9, 11, 13, 16, 32, 160, 320, 160, 320,
                              1, 11, 0));
        rows.push_back(mk_row(MODE_BICUBIC, 4096, -4096, 8192, -8192, 100, 100, 200, 200,
                              150, 150, 0, 0, 0));
        rows.push_back(mk_row(MODE_BILINEAR, 4096, -4096, 8192, -8192, 100, 100, 200, 200,
                              150, 130, 0, 0, 0));
        rows.push_back(mk_row(MODE_BICUBIC, 32767, -32768, 32767, -32768, 0, 0, 65535,
                              65535, 65535, 65535, 0, 0, 0));
        rows.push_back(mk_row(MODE_BICUBIC, 32767, -32768, -32768, 32767, 100, 100, 120,
                              120, 65535, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_BILINEAR, 32767, 32767, 32767, 32767, 100, 100, 110,
                              110, 65535, 65535, 0, 0, 0));
        rows.push_back(mk_row(MODE_BILINEAR, -32768, 32767, -32768, 32767, 200, 200, 100,
                              100, 150, 170, 0, 0, 0));
        rows.push_back(mk_row(MODE_BICUBIC, 1000, 2000, 3000, 4000, 200, 100, 100, 300,
                              250, 50, 0, 0, 0));
        rows.push_back(mk_row(MODE_BICUBIC, -1, 1, -1, 1, 65535, 65535, 0, 0, 1, 2,
                              0, 0, 0));
        rows.push_back(mk_row(MODE_BILINEAR, 0, 0, 0, 0, 0, 0, 1, 1, 65535, 65535,
                              0, 0, 0));
        rows.push_back(mk_row(MODE_BICUBIC, 12345, -23456, 30000, -30000, 10, 10, 11, 11,
                              10, 11, 0, 0, 0));
        rows.push_back(mk_row(MODE_BILINEAR, 12345, -23456, 30000, -30000, 10, 10, 13, 17,
                              11, 15, 0, 0, 0));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            send_sample(rows[k].smp, rows[k].fixed ? rows[k].answer : interpolate(rows[k].smp));
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
        end

        // Hold off until every directed result is back.
        i_valid <= 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);

        for (int n = 0; n < 500; ) begin
            burst = $urandom_range(1, 40);
            steady = ($urandom_range(0, 3) == 0);
            for (int b = 0; b < burst && n < 500; b++, n++) begin
                t_sample s;
                s = rand_sample();
                send_sample(s, interpolate(s));
                if (!steady && $urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 2));
            end
            gap = $urandom_range(0, 8);
            if (gap != 0) idle_cycles(gap);
        end
        i_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver stall pattern: segments of fixed duty, including stall-free runs.
    initial begin
        int seg_len, duty;
        @(posedge i_rst_n);
        forever begin
            seg_len = $urandom_range(5, 60);
            duty = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 80);
            repeat (seg_len) begin
                @(negedge i_clk);
                i_stall <= ($urandom_range(0, 99) < duty);
            end
        end
    end

    // Compare every result transfer with the oldest expected point.
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected result", o_result_value, 0);
            end else begin
                want = pending_points.pop_front();
                if (o_result_value !== want.value)
                    report_mismatch("result_value", o_result_value, want.value);
                if (o_invalid !== want.invalid)
                    report_mismatch("invalid", o_invalid, want.invalid);
            end
        end
    end

    // Final drain and verdict.
    initial begin
        wait (stimulus_done);
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("[quad_corner_bicubic_interpolator] OK");
        end else begin
            $display("[quad_corner_bicubic_interpolator] ERROR");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #400000;
        $display("[quad_corner_bicubic_interpolator] ERROR");
        $finish;
    end

endmodule
